// ===== design/afr_pkg.sv =====
`timescale 1ns / 1ps
package afr_pkg;

  localparam int unsigned Depth = 64;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  localparam int unsigned IdW    = 16;
  localparam int unsigned CostW  = 16;
  localparam int unsigned HeurW  = 10;
  localparam int unsigned CoordW = 2;
  localparam int unsigned PosW   = 7;
  localparam int unsigned StatW  = 2;
  localparam int unsigned FracW  = 8;
  localparam int unsigned FW     = CostW + FracW + 1;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = CoordW;

  localparam logic [CfgIdxW-1:0] CfgGoalRow = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgGoalCol = 1'd1;

  localparam logic [CoordW-1:0] CoordMax   = 2'd2;
  localparam logic [CoordW-1:0] GoalReset  = 2'd2;

  localparam logic [StatW-1:0] StatusDone  = 2'd0;
  localparam logic [StatW-1:0] StatusEmpty = 2'd1;
  localparam logic [StatW-1:0] StatusFull  = 2'd2;

  localparam logic ActInsert = 1'b0;
  localparam logic ActPop    = 1'b1;

  typedef struct packed {
    logic              action;
    logic [IdW-1:0]    node_id;
    logic              has_parent;
    logic [CostW-1:0]  parent_cost;
    logic [CostW-1:0]  own_cost;
    logic [CoordW-1:0] blank_row;
    logic [CoordW-1:0] blank_col;
  } in_item_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [IdW-1:0]   out_node_id;
    logic [CostW-1:0] out_cost;
    logic [HeurW-1:0] out_heuristic;
    logic [PosW-1:0]  insert_position;
  } out_item_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [CostW-1:0] cost;
    logic [HeurW-1:0] heur;
  } entry_t;

  typedef struct packed {
    logic   pop;
    entry_t entry;
  } job_t;

  typedef struct packed {
    logic [CntW-1:0] count;
  } ctl_stat_t;

  typedef enum logic [1:0] {
    CtlIdle,
    CtlBack,
    CtlPlace,
    CtlPop
  } ctl_state_e;

  function automatic logic [CoordW-1:0] clamp_coord(input logic [CoordW-1:0] v);
    return (v > CoordMax) ? CoordMax : v;
  endfunction

  function automatic logic [CoordW-1:0] abs_diff(input logic [CoordW-1:0] a,
                                                 input logic [CoordW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [HeurW-1:0] heur_lookup(input logic [CoordW-1:0] dr,
                                                   input logic [CoordW-1:0] dc);
    logic [HeurW-1:0] h;
    unique case ({dr, dc})
      4'b0000: h = 10'd0;
      4'b0001: h = 10'd256;
      4'b0010: h = 10'd512;
      4'b0100: h = 10'd256;
      4'b0101: h = 10'd362;
      4'b0110: h = 10'd572;
      4'b1000: h = 10'd512;
      4'b1001: h = 10'd572;
      4'b1010: h = 10'd724;
      default: h = 10'd0;
    endcase
    return h;
  endfunction

  function automatic logic [FW-1:0] f_value(input entry_t e);
    return FW'({e.cost, {FracW{1'b0}}}) + FW'(e.heur);
  endfunction

endpackage

// ===== design/afr_ram.sv =====
`timescale 1ns / 1ps
module afr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/afr_ctrl.sv =====
`timescale 1ns / 1ps
module afr_ctrl import afr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  job_t            job_i,
  output logic            job_stall_o,
  output logic            out_valid_o,
  output out_item_t       out_o,
  input  logic            out_stall_i,
  output logic            rd_en_o,
  output logic [PtrW-1:0] rd_addr_o,
  input  entry_t          rd_data_i,
  output logic            wr_en_o,
  output logic [PtrW-1:0] wr_addr_o,
  output entry_t          wr_data_o,
  output ctl_stat_t       stat_o
);

  function automatic logic [PtrW-1:0] phys(input logic [PtrW-1:0] head,
                                           input logic [CntW-1:0] idx);
    logic [CntW:0] sum;
    sum = (CntW+1)'(head) + (CntW+1)'(idx);
    if (sum >= (CntW+1)'(Depth)) begin
      sum = sum - (CntW+1)'(Depth);
    end
    return sum[PtrW-1:0];
  endfunction

  ctl_state_e      state_q, state_d;
  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] nxt_q, nxt_d;
  logic [CntW-1:0] cur_q, cur_d;
  logic [CntW-1:0] place_q, place_d;
  logic            more_q, more_d;
  logic            rd_valid_q, rd_valid_d;
  entry_t          new_q, new_d;
  logic [FW-1:0]   fnew_q, fnew_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;
  logic            load_ok;
  logic            job_fire;
  logic            entry_ge;

  assign load_ok     = !out_valid_q || !out_stall_i;
  assign job_stall_o = (state_q != CtlIdle) || !load_ok;
  assign job_fire    = job_valid_i && !job_stall_o;
  assign entry_ge    = f_value(rd_data_i) >= fnew_q;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    nxt_d      = nxt_q;
    cur_d      = cur_q;
    place_d    = place_q;
    more_d     = more_q;
    rd_valid_d = rd_valid_q;
    new_d      = new_q;
    fnew_d     = fnew_q;
    out_d      = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_en_o    = 1'b0;
    rd_addr_o  = phys(head_q, nxt_q);
    wr_en_o    = 1'b0;
    wr_addr_o  = phys(head_q, cur_q + CntW'(1));
    wr_data_o  = rd_data_i;

    unique case (state_q)
      CtlIdle: begin
        if (job_fire) begin
          if (job_i.pop == ActPop) begin
            if (count_q == '0) begin
              out_valid_d = 1'b1;
              out_d = '{status: StatusEmpty, out_node_id: '0, out_cost: '0,
                        out_heuristic: '0, insert_position: '0};
            end else begin
              rd_en_o   = 1'b1;
              rd_addr_o = head_q;
              state_d   = CtlPop;
            end
          end else begin
            new_d  = job_i.entry;
            fnew_d = f_value(job_i.entry);
            if (count_q == CntW'(Depth)) begin
              out_valid_d = 1'b1;
              out_d = '{status: StatusFull, out_node_id: job_i.entry.id,
                        out_cost: job_i.entry.cost, out_heuristic: job_i.entry.heur,
                        insert_position: '0};
            end else if (count_q == '0) begin
              place_d = '0;
              state_d = CtlPlace;
            end else begin
              nxt_d      = count_q - CntW'(1);
              more_d     = 1'b1;
              rd_valid_d = 1'b0;
              state_d    = CtlBack;
            end
          end
        end
      end
      CtlBack: begin
        if (more_q) begin
          rd_en_o    = 1'b1;
          cur_d      = nxt_q;
          rd_valid_d = 1'b1;
          if (nxt_q == '0) begin
            more_d = 1'b0;
          end else begin
            nxt_d = nxt_q - CntW'(1);
          end
        end
        if (rd_valid_q) begin
          if (entry_ge) begin
            wr_en_o = 1'b1;
            if (cur_q == '0) begin
              place_d = '0;
              state_d = CtlPlace;
            end
          end else begin
            place_d = cur_q + CntW'(1);
            state_d = CtlPlace;
          end
        end
      end
      CtlPlace: begin
        if (load_ok) begin
          wr_en_o     = 1'b1;
          wr_addr_o   = phys(head_q, place_q);
          wr_data_o   = new_q;
          count_d     = count_q + CntW'(1);
          out_valid_d = 1'b1;
          out_d = '{status: StatusDone, out_node_id: new_q.id, out_cost: new_q.cost,
                    out_heuristic: new_q.heur, insert_position: PosW'(place_q)};
          state_d = CtlIdle;
        end
      end
      CtlPop: begin
        if (load_ok) begin
          head_d      = (head_q == PtrW'(Depth - 1)) ? '0 : head_q + PtrW'(1);
          count_d     = count_q - CntW'(1);
          out_valid_d = 1'b1;
          out_d = '{status: StatusDone, out_node_id: rd_data_i.id,
                    out_cost: rd_data_i.cost, out_heuristic: rd_data_i.heur,
                    insert_position: '0};
          state_d = CtlIdle;
        end
      end
      default: state_d = CtlIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CtlIdle;
      head_q      <= '0;
      count_q     <= '0;
      more_q      <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      more_q      <= more_d;
      rd_valid_q  <= rd_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nxt_q   <= nxt_d;
    cur_q   <= cur_d;
    place_q <= place_d;
    new_q   <= new_d;
    fnew_q  <= fnew_d;
    out_q   <= out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_o        = out_q;
  assign stat_o.count = count_q;

endmodule

// ===== design/astar_sorted_frontier.sv =====
`timescale 1ns / 1ps
// Sorted A* open list, ordered by f = cost * 256 + heuristic, smallest first.
// Input channel in_valid_i / in_stall_o carries one in_item_t per transfer:
// action insert builds the cost (parent cost + 1, saturating, or own cost) and
// the Euclidean heuristic to the goal blank, then stores the node ahead of the
// first entry with an equal or greater f; action pop takes the front entry.
// Output channel out_valid_o / out_stall_i returns exactly one out_item_t per
// input transfer, in order, from an output register.
// A pop reads the front entry and returns it; a pop on an empty list or an
// insert into a full list only returns a status, and an insert into an empty
// list goes straight to the front. Any other insert walks the list from its
// tail, reading one entry and moving it up one slot per cycle through the
// single entry RAM and one f comparator, up to a smaller f or the front.
// The result is visible the cycle after the last step. A stalled result holds;
// the block accepts a new transfer while the result register is being emptied,
// and stalls its input while that result waits.
// Reset empties the list and sets both goal registers to 2; no clearing pass.
// cfg_we_i writes goal row (index 0) or goal column (index 1); the user must
// do so only while idle, as the block itself does not enforce it.
module astar_sorted_frontier import afr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic [CoordW-1:0] goal_row_q, goal_row_d;
  logic [CoordW-1:0] goal_col_q, goal_col_d;
  job_t              job;
  logic [CostW-1:0]  cost;
  logic              rd_en;
  logic [PtrW-1:0]   rd_addr;
  entry_t            rd_data;
  logic              wr_en;
  logic [PtrW-1:0]   wr_addr;
  entry_t            wr_data;
  ctl_stat_t         stat;

  always_comb begin
    goal_row_d = goal_row_q;
    goal_col_d = goal_col_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGoalRow: goal_row_d = cfg_wdata_i;
        CfgGoalCol: goal_col_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_row_q <= GoalReset;
      goal_col_q <= GoalReset;
    end else begin
      goal_row_q <= goal_row_d;
      goal_col_q <= goal_col_d;
    end
  end

  always_comb begin
    if (in_data_i.has_parent) begin
      cost = (in_data_i.parent_cost == '1) ? '1 : in_data_i.parent_cost + CostW'(1);
    end else begin
      cost = in_data_i.own_cost;
    end
    job.pop        = in_data_i.action;
    job.entry.id   = in_data_i.node_id;
    job.entry.cost = cost;
    job.entry.heur = heur_lookup(
        abs_diff(clamp_coord(in_data_i.blank_row), clamp_coord(goal_row_q)),
        abs_diff(clamp_coord(in_data_i.blank_col), clamp_coord(goal_col_q)));
  end

  afr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (in_valid_i),
    .job_i       (job),
    .job_stall_o (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_o       (out_data_o),
    .out_stall_i (out_stall_i),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .stat_o      (stat)
  );

  afr_ram #(
    .Width ($bits(entry_t)),
    .Depth (Depth)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      stat.count <= CntW'(Depth))
    else $error("entry count beyond list depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_data_o.status == StatusFull) |-> stat.count == CntW'(Depth))
    else $error("full status while list has room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_data_o.status == StatusEmpty) |-> stat.count == '0)
    else $error("empty status while list holds entries");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_o && out_data_o.status == StatusDone && out_data_o.insert_position != '0)
      |-> stat.count > CntW'(1))
    else $error("insert position past list tail");

endmodule
